[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/efa_pkg.sv]
package efa_pkg;

   localparam int MODE_W    = 3;
   localparam int COEF_W    = 5;
   localparam int SCALAR_W  = 8;
   localparam int INT_W     = 64;
   localparam int NUM_COEF  = 4;
   localparam int GF_P      = 31;

   // Working width of every unreduced sum in the datapath.
   localparam int SUM_W     = 15;

   // The integer is taken apart in radix-32 chunks, since 32 = 31 + 1.
   localparam int CHUNK_W   = 5;
   localparam int NUM_CHUNK = (INT_W + CHUNK_W - 1) / CHUNK_W;

   // floor(x / 31) = (x * 33826) >> 20, exact for x below 34952.
   localparam int DIV_MUL_W = 16;
   localparam int DIV_SHIFT = 20;
   localparam logic [DIV_MUL_W-1:0] DIV31_MUL = 16'd33826;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD      = 3'd0,
      MODE_SCALE    = 3'd1,
      MODE_MUL      = 3'd2,
      MODE_EQUAL    = 3'd3,
      MODE_FROM_INT = 3'd4
   } mode_type;

   typedef logic [COEF_W-1:0]  coef_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef coef_type [NUM_COEF-1:0] elem_type;
   typedef sum_type  [NUM_COEF-1:0] sums_type;

   // Binomial coefficients C(j,2) and C(j,3) for the chunk positions.
   localparam logic [7:0] BINOM2 [NUM_CHUNK] =
      '{8'd0, 8'd0, 8'd1, 8'd3, 8'd6, 8'd10, 8'd15, 8'd21, 8'd28, 8'd36, 8'd45, 8'd55,
        8'd66};
   localparam logic [7:0] BINOM3 [NUM_CHUNK] =
      '{8'd0, 8'd0, 8'd0, 8'd1, 8'd4, 8'd10, 8'd20, 8'd35, 8'd56, 8'd84, 8'd120,
        8'd165, 8'd220};

   function automatic sum_type div31(input sum_type x);
      logic [SUM_W+DIV_MUL_W-1:0] prod;
      prod = {{DIV_MUL_W{1'b0}}, x} * {{SUM_W{1'b0}}, DIV31_MUL};
      return sum_type'(prod[SUM_W+DIV_MUL_W-1:DIV_SHIFT]);
   endfunction

   function automatic coef_type mod31(input sum_type x);
      sum_type q;
      sum_type r;
      q = div31(x);
      r = x - sum_type'(q * sum_type'(GF_P));
      return r[COEF_W-1:0];
   endfunction

   // With 32^j = sum_i C(j,i) * 31^i, the value modulo 31^4 equals
   // S0 + 31*S1 + 31^2*S2 + 31^3*S3, where Si = sum_j C(j,i) * chunk_j.
   function automatic sums_type digit_sums(input logic [INT_W-1:0] v);
      logic [NUM_CHUNK*CHUNK_W-1:0] vp;
      sum_type n;
      sums_type s;
      vp = (NUM_CHUNK*CHUNK_W)'(v);
      s  = '0;
      for (int j = 0; j < NUM_CHUNK; j++) begin
         n    = sum_type'(vp[j*CHUNK_W +: CHUNK_W]);
         s[0] = s[0] + n;
         s[1] = s[1] + sum_type'(n * sum_type'(j));
         s[2] = s[2] + sum_type'(n * sum_type'(BINOM2[j]));
         s[3] = s[3] + sum_type'(n * sum_type'(BINOM3[j]));
      end
      return s;
   endfunction

endpackage

[sv/extension_field_alu_gf31_4.sv]
// Channel  Dir  Handshake            Payload
// req_     in   req_valid/req_stall  mode, a and b coefficients, scalar, int_value
// rsp_     out  rsp_valid/rsp_stall  r coefficients, equal
//
// One item is accepted per cycle while req_stall is low; a result passes every stage before it leaves.
// The depth is set by the base-31 carry chain of integer conversion, one digit per stage.
// Reset is synchronous and clears only the valid bits of the stages.
// Each stage holds while the stage after it is full and stalled, so bubbles are
// squeezed out and input keeps flowing until the pipeline is full.
module extension_field_alu_gf31_4
   import efa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [COEF_W-1:0]   req_a_coef0,
   input  logic [COEF_W-1:0]   req_a_coef1,
   input  logic [COEF_W-1:0]   req_a_coef2,
   input  logic [COEF_W-1:0]   req_a_coef3,
   input  logic [COEF_W-1:0]   req_b_coef0,
   input  logic [COEF_W-1:0]   req_b_coef1,
   input  logic [COEF_W-1:0]   req_b_coef2,
   input  logic [COEF_W-1:0]   req_b_coef3,
   input  logic [SCALAR_W-1:0] req_scalar,
   input  logic [INT_W-1:0]    req_int_value,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COEF_W-1:0]   rsp_r_coef0,
   output logic [COEF_W-1:0]   rsp_r_coef1,
   output logic [COEF_W-1:0]   rsp_r_coef2,
   output logic [COEF_W-1:0]   rsp_r_coef3,
   output logic                rsp_equal
);

   // Stage ready chain.
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_ready;

   // Stage 1: input register.
   logic                s1_valid_ff;
   logic [MODE_W-1:0]   s1_mode_in, s1_mode_ff;
   elem_type            s1_a_in, s1_a_ff;
   elem_type            s1_b_in, s1_b_ff;
   logic [SCALAR_W-1:0] s1_scalar_in, s1_scalar_ff;
   logic [INT_W-1:0]    s1_int_in, s1_int_ff;

   // Stage 2: unreduced coefficient values and digit sums.
   logic                s2_valid_ff;
   sums_type            s2_val_in, s2_val_ff;
   sums_type            s2_dsum_in, s2_dsum_ff;
   logic                s2_eq_in, s2_eq_ff;
   logic                s2_int_in, s2_int_ff;
   sum_type             s2_conv [2*NUM_COEF-1];
   sums_type            s2_fold;

   // Stage 3: reduced coefficients and the lowest digit.
   logic                s3_valid_ff;
   elem_type            s3_coef_in, s3_coef_ff;
   coef_type            s3_dig0_in, s3_dig0_ff;
   sum_type             s3_carry_in, s3_carry_ff;
   sum_type             s3_sum2_ff, s3_sum3_ff;
   logic                s3_eq_ff, s3_int_ff;

   // Stage 4.
   logic                s4_valid_ff;
   elem_type            s4_coef_ff;
   coef_type            s4_dig0_ff;
   coef_type            s4_dig1_in, s4_dig1_ff;
   sum_type             s4_carry_in, s4_carry_ff;
   sum_type             s4_sum3_ff;
   logic                s4_eq_ff, s4_int_ff;

   // Stage 5.
   logic                s5_valid_ff;
   elem_type            s5_coef_ff;
   coef_type            s5_dig0_ff, s5_dig1_ff;
   coef_type            s5_dig2_in, s5_dig2_ff;
   sum_type             s5_carry_in, s5_carry_ff;
   logic                s5_eq_ff, s5_int_ff;

   // Result register.
   logic                out_valid_ff;
   elem_type            out_coef_in, out_coef_ff;
   logic                out_eq_ff;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s5_ready  = !s5_valid_ff || out_ready;
   assign s4_ready  = !s4_valid_ff || s5_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   // ---------------- stage 1 ----------------
   assign s1_mode_in   = req_mode;
   assign s1_a_in      = {req_a_coef3, req_a_coef2, req_a_coef1, req_a_coef0};
   assign s1_b_in      = {req_b_coef3, req_b_coef2, req_b_coef1, req_b_coef0};
   assign s1_scalar_in = req_scalar;
   assign s1_int_in    = req_int_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_mode_ff   <= s1_mode_in;
         s1_a_ff      <= s1_a_in;
         s1_b_ff      <= s1_b_in;
         s1_scalar_ff <= s1_scalar_in;
         s1_int_ff    <= s1_int_in;
      end
   end

   // ---------------- stage 2 ----------------
   // Schoolbook product, then x^k for k >= 4 folds onto x^(k-4) and x^(k-3).
   always_comb begin
      for (int k = 0; k < 2*NUM_COEF-1; k++) begin
         s2_conv[k] = '0;
      end
      for (int i = 0; i < NUM_COEF; i++) begin
         for (int j = 0; j < NUM_COEF; j++) begin
            s2_conv[i+j] = s2_conv[i+j] + sum_type'(sum_type'(s1_a_ff[i]) *
                                                     sum_type'(s1_b_ff[j]));
         end
      end
      for (int i = 0; i < NUM_COEF; i++) begin
         s2_fold[i] = s2_conv[i];
      end
      for (int k = NUM_COEF; k < 2*NUM_COEF-1; k++) begin
         s2_fold[k-NUM_COEF]   = s2_fold[k-NUM_COEF] + s2_conv[k];
         s2_fold[k-NUM_COEF+1] = s2_fold[k-NUM_COEF+1] + s2_conv[k];
      end
   end

   always_comb begin
      s2_val_in = '0;
      s2_eq_in  = 1'b0;
      unique case (s1_mode_ff)
         MODE_ADD: begin
            for (int i = 0; i < NUM_COEF; i++) begin
               s2_val_in[i] = sum_type'(s1_a_ff[i]) + sum_type'(s1_b_ff[i]);
            end
         end
         MODE_SCALE: begin
            for (int i = 0; i < NUM_COEF; i++) begin
               s2_val_in[i] = sum_type'(sum_type'(s1_b_ff[i]) * sum_type'(s1_scalar_ff));
            end
         end
         MODE_MUL: begin
            s2_val_in = s2_fold;
         end
         MODE_EQUAL: begin
            s2_eq_in = (s1_a_ff == s1_b_ff);
         end
         default: begin
            s2_val_in = '0;
         end
      endcase
   end

   assign s2_dsum_in = digit_sums(s1_int_ff);
   assign s2_int_in  = (s1_mode_ff == MODE_FROM_INT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_val_ff  <= s2_val_in;
         s2_dsum_ff <= s2_dsum_in;
         s2_eq_ff   <= s2_eq_in;
         s2_int_ff  <= s2_int_in;
      end
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      for (int i = 0; i < NUM_COEF; i++) begin
         s3_coef_in[i] = mod31(s2_val_ff[i]);
      end
   end

   assign s3_dig0_in  = mod31(s2_dsum_ff[0]);
   assign s3_carry_in = s2_dsum_ff[1] + div31(s2_dsum_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_coef_ff  <= s3_coef_in;
         s3_dig0_ff  <= s3_dig0_in;
         s3_carry_ff <= s3_carry_in;
         s3_sum2_ff  <= s2_dsum_ff[2];
         s3_sum3_ff  <= s2_dsum_ff[3];
         s3_eq_ff    <= s2_eq_ff;
         s3_int_ff   <= s2_int_ff;
      end
   end

   // ---------------- stage 4 ----------------
   assign s4_dig1_in  = mod31(s3_carry_ff);
   assign s4_carry_in = s3_sum2_ff + div31(s3_carry_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_coef_ff  <= s3_coef_ff;
         s4_dig0_ff  <= s3_dig0_ff;
         s4_dig1_ff  <= s4_dig1_in;
         s4_carry_ff <= s4_carry_in;
         s4_sum3_ff  <= s3_sum3_ff;
         s4_eq_ff    <= s3_eq_ff;
         s4_int_ff   <= s3_int_ff;
      end
   end

   // ---------------- stage 5 ----------------
   // The carry out of the top digit is dropped, which is the reduction mod 31^4.
   assign s5_dig2_in  = mod31(s4_carry_ff);
   assign s5_carry_in = s4_sum3_ff + div31(s4_carry_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_ready) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         s5_coef_ff  <= s4_coef_ff;
         s5_dig0_ff  <= s4_dig0_ff;
         s5_dig1_ff  <= s4_dig1_ff;
         s5_dig2_ff  <= s5_dig2_in;
         s5_carry_ff <= s5_carry_in;
         s5_eq_ff    <= s4_eq_ff;
         s5_int_ff   <= s4_int_ff;
      end
   end

   // ---------------- result register ----------------
   assign out_coef_in = s5_int_ff ?
                        {mod31(s5_carry_ff), s5_dig2_ff, s5_dig1_ff, s5_dig0_ff} :
                        s5_coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_coef_ff <= out_coef_in;
         out_eq_ff   <= s5_eq_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_r_coef0 = out_coef_ff[0];
   assign rsp_r_coef1 = out_coef_ff[1];
   assign rsp_r_coef2 = out_coef_ff[2];
   assign rsp_r_coef3 = out_coef_ff[3];
   assign rsp_equal   = out_eq_ff;

endmodule

[sv/efa_checker.sv]
`include "assert_macros.svh"

module efa_checker
   import efa_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [COEF_W-1:0] rsp_r_coef0,
   input logic [COEF_W-1:0] rsp_r_coef1,
   input logic [COEF_W-1:0] rsp_r_coef2,
   input logic [COEF_W-1:0] rsp_r_coef3,
   input logic              rsp_equal
);

   logic                         rsp_held;
   logic [NUM_COEF*COEF_W-1:0]   rsp_coefs;
   logic [NUM_COEF*COEF_W:0]     rsp_payload;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_coefs   = {rsp_r_coef3, rsp_r_coef2, rsp_r_coef1, rsp_r_coef0};
   assign rsp_payload = {rsp_equal, rsp_coefs};

   // A result that is not taken stays on the port unchanged.
   `ASSERT_CLK(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp_payload), "stalled result changed")

   // An equality result carries no coefficients.
   `ASSERT_CLK(a_equal_zero, rsp_valid && rsp_equal |-> rsp_coefs == '0, "nonzero equality result")

   // Input is held back only when the output side is holding a result.
   `ASSERT_CLK(a_no_false_stall, !rsp_held |-> !req_stall, "input stalled while the output drains")

   // Nothing comes out in the cycle after reset.
   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind extension_field_alu_gf31_4 efa_checker u_efa_checker (.*);

[verif/extension_field_alu_gf31_4_tb.sv]
`timescale 1ns / 100ps

module extension_field_alu_gf31_4_tb
   import efa_pkg::*;
();

   // Mode codes that the block must answer with an all-zero result.
   localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

   localparam coef_type         UNREDUCED      = coef_type'(GF_P);
   localparam logic [INT_W-1:0] FOUR_DIGIT_MAX = INT_W'(GF_P ** NUM_COEF - 1);
   localparam int               LATENCY        = 5;

   typedef coef_type coef_set_type [NUM_COEF];

   typedef struct {
      logic [MODE_W-1:0]   mode;
      coef_set_type        a;
      coef_set_type        b;
      logic [SCALAR_W-1:0] scalar;
      logic [INT_W-1:0]    int_value;
   } alu_op_type;

   typedef struct {
      coef_set_type r;
      logic         equal;
   } alu_result_type;

   typedef struct {
      alu_op_type     op;
      bit             known;
      alu_result_type want;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode;
   logic [COEF_W-1:0]   req_a_coef0, req_a_coef1, req_a_coef2, req_a_coef3;
   logic [COEF_W-1:0]   req_b_coef0, req_b_coef1, req_b_coef2, req_b_coef3;
   logic [SCALAR_W-1:0] req_scalar;
   logic [INT_W-1:0]    req_int_value;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COEF_W-1:0]   rsp_r_coef0, rsp_r_coef1, rsp_r_coef2, rsp_r_coef3;
   logic                rsp_equal;

   alu_result_type   pending_results [$];
   directed_row_type steps [$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               mismatch_count = 0;
   int               results_seen = 0;
   int               ops_sent = 0;
   int               mode_count [8];

   extension_field_alu_gf31_4 dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_a_coef0   (req_a_coef0),
      .req_a_coef1   (req_a_coef1),
      .req_a_coef2   (req_a_coef2),
      .req_a_coef3   (req_a_coef3),
      .req_b_coef0   (req_b_coef0),
      .req_b_coef1   (req_b_coef1),
      .req_b_coef2   (req_b_coef2),
      .req_b_coef3   (req_b_coef3),
      .req_scalar    (req_scalar),
      .req_int_value (req_int_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_r_coef0   (rsp_r_coef0),
      .rsp_r_coef1   (rsp_r_coef1),
      .rsp_r_coef2   (rsp_r_coef2),
      .rsp_r_coef3   (rsp_r_coef3),
      .rsp_equal     (rsp_equal)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Expected result of one operation in F31[x]/(x^4 - x - 1).
   function automatic alu_result_type gf31_compute(input alu_op_type op);
      alu_result_type   res;
      int               c [7];
      logic [INT_W-1:0] v;
      res.equal = 1'b0;
      for (int i = 0; i < NUM_COEF; i++) res.r[i] = '0;
      for (int i = 0; i < 7; i++) c[i] = 0;
      v = op.int_value;
      case (op.mode)
         MODE_ADD: begin
            for (int i = 0; i < NUM_COEF; i++)
               res.r[i] = coef_type'((int'(op.a[i]) + int'(op.b[i])) % GF_P);
         end
         MODE_SCALE: begin
            for (int i = 0; i < NUM_COEF; i++)
               res.r[i] = coef_type'((int'(op.b[i]) * int'(op.scalar)) % GF_P);
         end
         MODE_MUL: begin
            for (int i = 0; i < NUM_COEF; i++)
               for (int j = 0; j < NUM_COEF; j++)
                  c[i+j] += int'(op.a[i]) * int'(op.b[j]);
            // Fold the high terms back: x^4 = x + 1, x^5 = x^2 + x, x^6 = x^3 + x^2.
            res.r[0] = coef_type'((c[0] + c[4]) % GF_P);
            res.r[1] = coef_type'((c[1] + c[4] + c[5]) % GF_P);
            res.r[2] = coef_type'((c[2] + c[5] + c[6]) % GF_P);
            res.r[3] = coef_type'((c[3] + c[6]) % GF_P);
         end
         MODE_EQUAL: begin
            res.equal = 1'b1;
            for (int i = 0; i < NUM_COEF; i++)
               if (op.a[i] != op.b[i]) res.equal = 1'b0;
         end
         MODE_FROM_INT: begin
            for (int i = 0; i < NUM_COEF; i++) begin
               res.r[i] = coef_type'(v % INT_W'(GF_P));
               v = v / INT_W'(GF_P);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic directed_row_type plan_row(input logic [MODE_W-1:0] mode,
                                                 input coef_set_type a, input coef_set_type b,
                                                 input logic [SCALAR_W-1:0] scalar,
                                                 input logic [INT_W-1:0] value,
                                                 input bit known, input coef_set_type r,
                                                 input logic equal);
      directed_row_type row;
      row.op.mode      = mode;
      row.op.a         = a;
      row.op.b         = b;
      row.op.scalar    = scalar;
      row.op.int_value = value;
      row.known        = known;
      row.want.r       = r;
      row.want.equal   = equal;
      return row;
   endfunction

   function automatic coef_type draw_coef();
      return ($urandom_range(15) == 0) ? UNREDUCED : coef_type'($urandom_range(GF_P - 1));
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_op(input alu_op_type op, input alu_result_type expected);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode      = op.mode;
      req_a_coef0   = op.a[0];
      req_a_coef1   = op.a[1];
      req_a_coef2   = op.a[2];
      req_a_coef3   = op.a[3];
      req_b_coef0   = op.b[0];
      req_b_coef1   = op.b[1];
      req_b_coef2   = op.b[2];
      req_b_coef3   = op.b[3];
      req_scalar    = op.scalar;
      req_int_value = op.int_value;
      req_valid     = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(expected);
      ops_sent++;
      mode_count[op.mode]++;
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      alu_op_type op;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(19) == 0)
            op.mode = MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7));
         else
            op.mode = MODE_W'($urandom_range(MODE_ADD, MODE_FROM_INT));
         for (int i = 0; i < NUM_COEF; i++) begin
            op.a[i] = draw_coef();
            op.b[i] = draw_coef();
         end
         // Half of the equality tests compare an element with itself.
         if (op.mode == MODE_EQUAL && $urandom_range(1) == 1) op.b = op.a;
         op.scalar = SCALAR_W'($urandom_range(255));
         case ($urandom_range(9))
            0:       op.int_value = INT_W'($urandom_range(32'(FOUR_DIGIT_MAX)));
            1:       op.int_value = '1;
            default: op.int_value = {$urandom, $urandom};
         endcase
         send_op(op, gf31_compute(op));
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin : check_results
      coef_set_type   got;
      alu_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         got[0] = rsp_r_coef0;
         got[1] = rsp_r_coef1;
         got[2] = rsp_r_coef2;
         got[3] = rsp_r_coef3;
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with no operation outstanding");
         end else begin
            want = pending_results.pop_front();
            for (int i = 0; i < NUM_COEF; i++)
               if (got[i] !== want.r[i])
                  report_mismatch($sformatf("result %0d: r_coef%0d got %0d, expected %0d",
                                            results_seen, i, got[i], want.r[i]));
            if (rsp_equal !== want.equal)
               report_mismatch($sformatf("result %0d: equal got %0b, expected %0b",
                                         results_seen, rsp_equal, want.equal));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      foreach (mode_count[m]) mode_count[m] = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_ADD;
      req_a_coef0   = '0;
      req_a_coef1   = '0;
      req_a_coef2   = '0;
      req_a_coef3   = '0;
      req_b_coef0   = '0;
      req_b_coef1   = '0;
      req_b_coef2   = '0;
      req_b_coef3   = '0;
      req_scalar    = '0;
      req_int_value = '0;

      steps.push_back(plan_row(MODE_ADD, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 0, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_ADD, '{30, 30, 30, 30}, '{30, 30, 30, 30}, 255, '1,
                               1, '{29, 29, 29, 29}, 0));
      steps.push_back(plan_row(MODE_ADD, '{31, 31, 0, 31}, '{0, 31, 5, 1}, 0, 0,
                               1, '{0, 0, 5, 1}, 0));
      steps.push_back(plan_row(MODE_ADD, '{1, 2, 3, 4}, '{30, 29, 28, 27}, 0, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_SCALE, '{7, 7, 7, 7}, '{30, 30, 30, 30}, 255, 0,
                               0, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_SCALE, '{0, 0, 0, 0}, '{1, 2, 3, 4}, 0, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_SCALE, '{30, 30, 30, 30}, '{1, 2, 3, 4}, 1, '1,
                               1, '{1, 2, 3, 4}, 0));
      steps.push_back(plan_row(MODE_SCALE, '{0, 0, 0, 0}, '{31, 31, 31, 31}, 255, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_SCALE, '{0, 0, 0, 0}, '{1, 0, 0, 0}, 32, 0,
                               1, '{1, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_MUL, '{1, 0, 0, 0}, '{5, 6, 7, 8}, 0, 0,
                               1, '{5, 6, 7, 8}, 0));
      steps.push_back(plan_row(MODE_MUL, '{0, 1, 0, 0}, '{0, 0, 0, 1}, 0, 0,
                               1, '{1, 1, 0, 0}, 0));
      steps.push_back(plan_row(MODE_MUL, '{0, 0, 0, 1}, '{0, 0, 0, 1}, 0, 0,
                               1, '{0, 0, 1, 1}, 0));
      steps.push_back(plan_row(MODE_MUL, '{30, 30, 30, 30}, '{30, 30, 30, 30}, 255, '1,
                               0, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_MUL, '{31, 31, 31, 31}, '{30, 30, 30, 30}, 0, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_MUL, '{3, 14, 15, 9}, '{26, 5, 3, 5}, 0, 0,
                               0, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_EQUAL, '{3, 14, 15, 9}, '{3, 14, 15, 9}, 255, '1,
                               1, '{0, 0, 0, 0}, 1));
      steps.push_back(plan_row(MODE_EQUAL, '{30, 30, 30, 30}, '{30, 30, 30, 29}, 0, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_EQUAL, '{31, 0, 0, 0}, '{0, 0, 0, 0}, 0, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_EQUAL, '{31, 31, 31, 31}, '{31, 31, 31, 31}, 0, 0,
                               1, '{0, 0, 0, 0}, 1));
      steps.push_back(plan_row(MODE_FROM_INT, '{30, 30, 30, 30}, '{1, 1, 1, 1}, 255, 0,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_FROM_INT, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 0, 31,
                               1, '{0, 1, 0, 0}, 0));
      steps.push_back(plan_row(MODE_FROM_INT, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 0,
                               FOUR_DIGIT_MAX, 1, '{30, 30, 30, 30}, 0));
      steps.push_back(plan_row(MODE_FROM_INT, '{0, 0, 0, 0}, '{0, 0, 0, 0}, 0, '1,
                               0, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_RSVD5, '{30, 30, 30, 30}, '{30, 30, 30, 30}, 255, '1,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_RSVD6, '{1, 2, 3, 4}, '{5, 6, 7, 8}, 255, '1,
                               1, '{0, 0, 0, 0}, 0));
      steps.push_back(plan_row(MODE_RSVD7, '{9, 9, 9, 9}, '{9, 9, 9, 9}, 3, 31,
                               1, '{0, 0, 0, 0}, 0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 32;
      recv_idle_pct = 82;
      foreach (steps[k])
         send_op(steps[k].op, steps[k].known ? steps[k].want : gf31_compute(steps[k].op));
      run_random(400);

      send_idle_pct = 82;
      recv_idle_pct = 32;
      run_random(400);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(400);
      req_valid = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);

      $display("%0d operations sent (%0d directed), %0d results checked",
               ops_sent, steps.size(), results_seen);
      $display("per mode add/scale/mul/equal/from_int/unused: %0d/%0d/%0d/%0d/%0d/%0d",
               mode_count[MODE_ADD], mode_count[MODE_SCALE], mode_count[MODE_MUL],
               mode_count[MODE_EQUAL], mode_count[MODE_FROM_INT],
               mode_count[MODE_RSVD5] + mode_count[MODE_RSVD6] + mode_count[MODE_RSVD7]);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/efa_pkg.sv
sv/extension_field_alu_gf31_4.sv
sv/efa_checker.sv
verif/extension_field_alu_gf31_4_tb.sv
